### sv/imudi_pkg.sv
// Shared types, constants and helpers for the IMU displacement integrator.
package imudi_pkg;

    // Nanoseconds in one second
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Saturation limits for signed 32-bit results
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh80000000;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // Gate register reset values (0.03 and 1.0 in Q16.16)
    localparam logic [30:0] GATE_LOW_RST  = 31'd1966;
    localparam logic [30:0] GATE_HIGH_RST = 31'd65536;

    // Configuration register indexes
    localparam logic [0:0] CFG_GATE_LOW  = 1'b0;
    localparam logic [0:0] CFG_GATE_HIGH = 1'b1;

    // Stream item modes (tuser)
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Field layout of the stream data words
    localparam int TDATA_W  = 256;
    localparam int SEC_LSB  = 0;
    localparam int NSEC_LSB = 32;
    localparam int VAL_LSB  = 62;
    localparam int VAL_W    = 32;
    localparam int NUM_VAL  = 6;
    localparam int NUM_AXIS = 3;

    // Per-lane stage strobes
    typedef struct packed {
        logic ld_ops;
        logic mul_a;
        logic mul_b;
        logic sum;
    } t_lane_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = Q_MAX;
        end else if (v < SAT_LO) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/imudi_dt_unit.sv
// Time step unit: timestamp difference to saturated fixed point by reciprocal multiplication.
module imudi_dt_unit
    import imudi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_sec_new,
    input  logic [31:0]        i_sec_prev,
    input  logic [29:0]        i_nsec_new,
    input  logic [29:0]        i_nsec_prev,
    output logic               o_done,
    output logic signed [31:0] o_dt
);

    localparam int INT_W  = 32 - FRAC_BITS;
    localparam int SHIFT  = 61 - FRAC_BITS;
    localparam int FINE_W = 30 + FRAC_BITS;
    localparam logic signed [32:0] NS_S    = {3'b000, NS_PER_SEC};
    localparam logic signed [33:0] SEC_LIM = 34'sd1 <<< (INT_W - 1);
    // floor(2^61 / 1e9)
    localparam logic [31:0] RECIP = 32'd2305843009;

    logic signed [32:0]    w_ds;
    logic signed [32:0]    w_dn;
    logic signed [32:0]    w_rem;
    logic signed [2:0]     w_k;
    logic signed [33:0]    w_secs;
    logic [FINE_W-1:0]     w_fine;
    logic [FINE_W-1:0]     w_left;
    logic                  w_carry;

    logic [2:0]            r_stage;
    logic                  r_hi_sat;
    logic                  r_lo_sat;
    logic [INT_W-1:0]      r_int;
    logic [29:0]           r_rem;
    logic [61:0]           r_prod;
    logic [FRAC_BITS-1:0]  r_q0;
    logic [FINE_W-1:0]     r_back;
    logic [FRAC_BITS-1:0]  r_frac;

    // Fold the nanosecond difference into [0, 1e9) and carry into seconds
    always_comb begin
        w_ds = $signed({1'b0, i_sec_new}) - $signed({1'b0, i_sec_prev});
        w_dn = $signed({3'b000, i_nsec_new}) - $signed({3'b000, i_nsec_prev});
        if (w_dn < -NS_S) begin
            w_k   = -3'sd2;
            w_rem = w_dn + NS_S + NS_S;
        end else if (w_dn < 33'sd0) begin
            w_k   = -3'sd1;
            w_rem = w_dn + NS_S;
        end else if (w_dn >= NS_S) begin
            w_k   = 3'sd1;
            w_rem = w_dn - NS_S;
        end else begin
            w_k   = 3'sd0;
            w_rem = w_dn;
        end
        w_secs = 34'(w_ds) + 34'(w_k);
    end

    // Estimate from the reciprocal is the exact quotient or one below it
    assign w_fine  = {r_rem, {FRAC_BITS{1'b0}}};
    assign w_left  = w_fine - r_back;
    assign w_carry = (w_left >= {{FRAC_BITS{1'b0}}, NS_PER_SEC});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi_sat <= (w_secs >= SEC_LIM);
            r_lo_sat <= (w_secs < -SEC_LIM);
            r_int    <= w_secs[INT_W-1:0];
            r_rem    <= w_rem[29:0];
        end
        if (r_stage[0]) begin
            r_prod <= {32'd0, r_rem} * {30'd0, RECIP};
        end
        if (r_stage[1]) begin
            r_q0   <= r_prod[SHIFT +: FRAC_BITS];
            r_back <= {30'd0, r_prod[SHIFT +: FRAC_BITS]} * {{FRAC_BITS{1'b0}}, NS_PER_SEC};
        end
        if (r_stage[2]) begin
            r_frac <= r_q0 + FRAC_BITS'(w_carry);
        end
    end

    assign o_done = r_stage[2];
    assign o_dt   = r_hi_sat ? Q_MAX : (r_lo_sat ? Q_MIN : $signed({r_int, r_frac}));

endmodule

### sv/imudi_lane.sv
// One axis lane: bias removal, displacement and angle products with floor shifts and saturation.
module imudi_lane
    import imudi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  t_lane_ctl          i_ctl,
    input  logic signed [31:0] i_acc_new,
    input  logic signed [31:0] i_acc_prev,
    input  logic signed [31:0] i_acc_bias,
    input  logic signed [31:0] i_rate_prev,
    input  logic signed [31:0] i_rate_bias,
    input  logic signed [31:0] i_dt,
    output logic signed [31:0] o_disp,
    output logic signed [31:0] o_turn
);

    logic signed [33:0] w_da_sum;
    logic signed [32:0] w_a0_sum;
    logic signed [32:0] w_r0_sum;
    logic signed [31:0] w_t1;

    logic signed [31:0] r_da;
    logic signed [31:0] r_a0;
    logic signed [31:0] r_r0;
    logic signed [63:0] r_p_da;
    logic signed [63:0] r_p_lin;
    logic signed [63:0] r_p_turn;
    logic signed [63:0] r_p_quad;
    logic signed [63:0] r_lin;
    logic signed [31:0] r_turn;
    logic signed [31:0] r_disp;

    assign w_da_sum = 34'(i_acc_new) - 34'(i_acc_prev) - 34'(i_acc_bias);
    assign w_a0_sum = 33'(i_acc_prev) - 33'(i_acc_bias);
    assign w_r0_sum = 33'(i_rate_prev) - 33'(i_rate_bias);
    assign w_t1     = sat32(r_p_da >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_ops) begin
            r_da <= sat32(64'(w_da_sum));
            r_a0 <= sat32(64'(w_a0_sum));
            r_r0 <= sat32(64'(w_r0_sum));
        end
        if (i_ctl.mul_a) begin
            r_p_da   <= r_da * i_dt;
            r_p_lin  <= r_a0 * i_dt;
            r_p_turn <= r_r0 * i_dt;
        end
        if (i_ctl.mul_b) begin
            r_p_quad <= w_t1 * i_dt;
            r_lin    <= r_p_lin >>> FRAC_BITS;
            r_turn   <= sat32(r_p_turn >>> FRAC_BITS);
        end
        if (i_ctl.sum) begin
            // half of da*dt^2 plus a0*dt
            r_disp <= sat32((r_p_quad >>> (FRAC_BITS + 1)) + r_lin);
        end
    end

    assign o_disp = r_disp;
    assign o_turn = r_turn;

endmodule

### sv/imudi_merge.sv
// Merge stage: x/y window gate over the lane results and the output register.
module imudi_merge
    import imudi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [30:0]          i_gate_low,
    input  logic [30:0]          i_gate_high,
    input  logic [31:0]          i_sec,
    input  logic [29:0]          i_nsec,
    input  logic signed [31:0]   i_disp [NUM_AXIS],
    input  logic signed [31:0]   i_turn [NUM_AXIS],
    input  logic                 i_tready,
    output logic                 o_tvalid,
    output logic [TDATA_W-1:0]   o_tdata,
    output logic                 o_block
);

    logic signed [31:0] w_lo;
    logic signed [31:0] w_hi;
    logic               w_pass;
    logic               r_valid;
    logic [TDATA_W-1:0] r_data;

    assign w_lo   = $signed({1'b0, i_gate_low});
    assign w_hi   = $signed({1'b0, i_gate_high});
    assign w_pass = ((i_disp[0] > w_lo) || (i_disp[1] > w_lo))
                 && ((i_disp[0] < w_hi) || (i_disp[1] < w_hi));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire && w_pass) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_pass) begin
            r_data <= {2'b00, i_turn[2], i_turn[1], i_turn[0],
                       i_disp[2], i_disp[1], i_disp[0], i_nsec, i_sec};
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_block  = r_valid && !i_tready;

endmodule

### sv/imu_displacement_integrator_core.sv
// Top level of the IMU displacement integrator: sample store, tick sequencer, lanes, merge.
// Sample transaction (tuser = 0): stored at the accepting edge.
// Tick transaction (tuser = 1): the time step is computed (reciprocal multiply and correction),
// then the lane products and sum, then the result is written to the output register.
// The input is held off until the tick finishes, longer while a waiting result is stalled.
// Reset (synchronous, active low) zeroes the samples, bias and count and loads gate defaults.
module imu_displacement_integrator_core
    import imudi_pkg::*;
#(
    parameter int CAPTURE_INDEX = 5,
    parameter int FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] stamp_sec, [61:32] stamp_nsec, [93:62] accel_x, [125:94] accel_y,
    // [157:126] accel_z, [189:158] rate_x, [221:190] rate_y, [253:222] rate_z, [255:254] zero
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // [0] mode: 0 = sample, 1 = integration tick
    input  logic               s_axis_tuser,
    // Result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [31:0] out_sec, [61:32] out_nsec, [93:62] disp_x, [125:94] disp_y,
    // [157:126] disp_z, [189:158] turn_x, [221:190] turn_y, [253:222] turn_z, [255:254] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    // Configuration writes
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);

    localparam int CNT_W = $clog2(CAPTURE_INDEX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DT,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_FIN
    } t_state;

    t_state             r_state;

    // Sample store: newest, previous (as of last tick), captured bias
    logic [31:0]        r_new_sec;
    logic [29:0]        r_new_nsec;
    logic signed [31:0] r_new_val  [NUM_VAL];
    logic [31:0]        r_prev_sec;
    logic [29:0]        r_prev_nsec;
    logic signed [31:0] r_prev_val [NUM_VAL];
    logic signed [31:0] r_bias     [NUM_VAL];
    logic [CNT_W-1:0]   r_count;
    logic [30:0]        r_gate_low;
    logic [30:0]        r_gate_high;

    logic               w_in_acc;
    logic               w_sample_wr;
    logic               w_tick;
    logic               w_dt_done;
    logic signed [31:0] w_dt;
    logic               w_out_block;
    logic               w_fire;
    t_lane_ctl          w_ctl;
    logic signed [31:0] w_in_val [NUM_VAL];
    logic signed [31:0] w_disp   [NUM_AXIS];
    logic signed [31:0] w_turn   [NUM_AXIS];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_sample_wr   = w_in_acc && (s_axis_tuser == MODE_SAMPLE);
    assign w_tick        = w_in_acc && (s_axis_tuser == MODE_TICK);

    // Finish a tick only once the output register can take a new result
    assign w_fire = (r_state == ST_FIN) && !w_out_block;

    assign w_ctl.ld_ops = (r_state == ST_DT);
    assign w_ctl.mul_a  = (r_state == ST_M1);
    assign w_ctl.mul_b  = (r_state == ST_M2);
    assign w_ctl.sum    = (r_state == ST_M3);

    genvar gv;
    generate
        for (gv = 0; gv < NUM_VAL; gv++) begin : g_unpack
            assign w_in_val[gv] = $signed(s_axis_tdata[VAL_LSB + VAL_W*gv +: VAL_W]);
        end
    endgenerate

    // Tick sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_tick) begin
                        r_state <= ST_DT;
                    end
                end
                ST_DT: begin
                    if (w_dt_done) begin
                        r_state <= ST_M1;
                    end
                end
                ST_M1:   r_state <= ST_M2;
                ST_M2:   r_state <= ST_M3;
                ST_M3:   r_state <= ST_FIN;
                ST_FIN: begin
                    if (w_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Sample store; bias latches on the CAPTURE_INDEX-th sample, count then holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_sec   <= '0;
            r_new_nsec  <= '0;
            r_prev_sec  <= '0;
            r_prev_nsec <= '0;
            r_count     <= '0;
            for (int i = 0; i < NUM_VAL; i++) begin
                r_new_val[i]  <= '0;
                r_prev_val[i] <= '0;
                r_bias[i]     <= '0;
            end
        end else begin
            if (w_sample_wr) begin
                r_new_sec  <= s_axis_tdata[SEC_LSB +: 32];
                r_new_nsec <= s_axis_tdata[NSEC_LSB +: 30];
                for (int i = 0; i < NUM_VAL; i++) begin
                    r_new_val[i] <= w_in_val[i];
                end
                if (r_count < CNT_W'(CAPTURE_INDEX)) begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_count == CNT_W'(CAPTURE_INDEX - 1)) begin
                        for (int i = 0; i < NUM_VAL; i++) begin
                            r_bias[i] <= w_in_val[i];
                        end
                    end
                end
            end
            // Newest sample rolls into previous when a tick completes
            if (w_fire) begin
                r_prev_sec  <= r_new_sec;
                r_prev_nsec <= r_new_nsec;
                for (int i = 0; i < NUM_VAL; i++) begin
                    r_prev_val[i] <= r_new_val[i];
                end
            end
        end
    end

    // Gate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_low  <= GATE_LOW_RST;
            r_gate_high <= GATE_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GATE_LOW:  r_gate_low  <= i_cfg_data;
                CFG_GATE_HIGH: r_gate_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imudi_dt_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_tick),
        .i_sec_new   (r_new_sec),
        .i_sec_prev  (r_prev_sec),
        .i_nsec_new  (r_new_nsec),
        .i_nsec_prev (r_prev_nsec),
        .o_done      (w_dt_done),
        .o_dt        (w_dt)
    );

    // One lane per axis: acceleration and rate of that axis
    generate
        for (gv = 0; gv < NUM_AXIS; gv++) begin : g_lane
            imudi_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_acc_new   (r_new_val[gv]),
                .i_acc_prev  (r_prev_val[gv]),
                .i_acc_bias  (r_bias[gv]),
                .i_rate_prev (r_prev_val[NUM_AXIS + gv]),
                .i_rate_bias (r_bias[NUM_AXIS + gv]),
                .i_dt        (w_dt),
                .o_disp      (w_disp[gv]),
                .o_turn      (w_turn[gv])
            );
        end
    endgenerate

    imudi_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_gate_low  (r_gate_low),
        .i_gate_high (r_gate_high),
        .i_sec       (r_new_sec),
        .i_nsec      (r_new_nsec),
        .i_disp      (w_disp),
        .i_turn      (w_turn),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_tdata     (m_axis_tdata),
        .o_block     (w_out_block)
    );

    // A tick transaction holds off the input for its whole computation
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> !s_axis_tready)
        else $error("input taken right after a tick");

    // Sample count stops at the capture index
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPTURE_INDEX))
        else $error("sample count past capture index");

    // Time step completes only while the sequencer waits for it
    a_dt_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dt_done |-> (r_state == ST_DT))
        else $error("time step done outside its state");

    // A new result appears only from the finishing state of a tick
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_FIN))
        else $error("result valid without a finished tick");

endmodule
